FILE: hdl/flight_phase_sequencer_assert.svh
// ----------------------------------------------------------------------------
// flight phase sequencer assertion macros
// concurrent assertion wrappers, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef FLIGHT_PHASE_SEQUENCER_ASSERT_SVH
`define FLIGHT_PHASE_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
// checked only while out of reset
`define FPS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("fps assertion failed");
// checked on every edge, reset included
`define FPS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("fps assertion failed");
`else
`define FPS_ASSERT(lbl, clk, rst_n, prop)
`define FPS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: hdl/fps_pkg.sv
// ----------------------------------------------------------------------------
// fps_pkg
// types, codes and reset values shared by the flight phase sequencer
// ----------------------------------------------------------------------------
package fps_pkg;

    localparam int ACTION_W  = 4;
    localparam int ALT_W     = 24;
    localparam int HEIGHT_W  = 23;
    localparam int TIME_W    = 20;
    localparam int STEP_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 23;

    localparam int IN_DEPTH_DEF  = 2;
    localparam int OUT_DEPTH_DEF = 2;

    localparam logic [TIME_W-1:0] TIMER_MAX = '1;

    localparam logic [HEIGHT_W-1:0] TAKEOFF_HEIGHT_RST = 23'd1500;
    localparam logic [HEIGHT_W-1:0] HOVER_HEIGHT_RST   = 23'd1000;
    localparam logic [HEIGHT_W-1:0] LANDED_HEIGHT_RST  = 23'd500;
    localparam logic [TIME_W-1:0]   TAKEOFF_LIMIT_RST  = 20'd10000;
    localparam logic [TIME_W-1:0]   HOVER_LIMIT_RST    = 20'd5000;
    localparam logic [TIME_W-1:0]   LANDING_LIMIT_RST  = 20'd10000;
    // 1.25 margin on a 200 ms update period
    localparam logic [STEP_W-1:0]   MAX_STEP_RST       = 16'd250;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TAKEOFF_HEIGHT = 3'd0,
        REG_HOVER_HEIGHT   = 3'd1,
        REG_LANDED_HEIGHT  = 3'd2,
        REG_TAKEOFF_LIMIT  = 3'd3,
        REG_HOVER_LIMIT    = 3'd4,
        REG_LANDING_LIMIT  = 3'd5,
        REG_MAX_STEP       = 3'd6
    } t_reg;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK     = 4'd0,
        ACT_POSITION = 4'd1,
        ACT_ARM      = 4'd2,
        ACT_DISARM   = 4'd3,
        ACT_TAKEOFF  = 4'd4,
        ACT_HOVER    = 4'd5,
        ACT_TRACK    = 4'd6,
        ACT_LAND     = 4'd7,
        ACT_SHUTDOWN = 4'd8
    } t_action;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TICK,
        OP_POSITION,
        OP_ARM,
        OP_DISARM,
        OP_TAKEOFF,
        OP_HOVER,
        OP_TRACK,
        OP_LAND,
        OP_SHUTDOWN
    } t_op;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_DISARMED   = 4'd1,
        PH_ARMED      = 4'd2,
        PH_TAKING_OFF = 4'd3,
        PH_TAKEN_OFF  = 4'd4,
        PH_HOVERING   = 4'd5,
        PH_HOVERED    = 4'd6,
        PH_TRACKING   = 4'd7,
        PH_LANDING    = 4'd8,
        PH_LANDED     = 4'd9,
        PH_ERROR      = 4'd10
    } t_phase;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_ARM     = 3'd1,
        CMD_DISARM  = 3'd2,
        CMD_TAKEOFF = 3'd3,
        CMD_HOVER   = 3'd4,
        CMD_LAND    = 3'd5
    } t_cmd;

    typedef struct packed {
        logic [HEIGHT_W-1:0] takeoff_height;
        logic [HEIGHT_W-1:0] hover_height;
        logic [HEIGHT_W-1:0] landed_height;
        logic [TIME_W-1:0]   takeoff_limit;
        logic [TIME_W-1:0]   hover_limit;
        logic [TIME_W-1:0]   landing_limit;
        logic [STEP_W-1:0]   max_step;
    } t_cfg;

    typedef struct packed {
        t_op                op;
        logic signed [ALT_W-1:0] altitude;
        logic [STEP_W-1:0]  step;
        logic               ok;
    } t_item;

    typedef struct packed {
        t_phase phase;
        logic   accepted;
        t_cmd   command;
        logic   timed_out;
        logic   no_position;
    } t_result;

endpackage

FILE: hdl/flight_phase_sequencer.sv
// ----------------------------------------------------------------------------
// flight_phase_sequencer
// flight phase control for one vehicle, queue-style ports on both sides
// ----------------------------------------------------------------------------
// One item per cycle sustained while results are popped: every item gives
// exactly one result, in order. An item is registered in the input queue
// and is carried out by the back end (one saturating timer add, one timer
// compare and one altitude compare), then its result is registered in the
// output queue and sits on the result ports until popped.
// full rises only when both queues are full because results are not taken.
// Configuration writes take effect at the next edge; the user must make
// them only while idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module flight_phase_sequencer #(
    parameter int IN_DEPTH  = fps_pkg::IN_DEPTH_DEF,
    parameter int OUT_DEPTH = fps_pkg::OUT_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [fps_pkg::ACTION_W-1:0]   i_action,
    input  logic signed [fps_pkg::ALT_W-1:0] i_altitude_mm,
    input  logic [fps_pkg::STEP_W-1:0]     i_elapsed_ms,
    input  logic                           i_command_ok,
    output logic                           empty,
    input  logic                           pop,
    output logic [3:0]                     o_phase,
    output logic                           o_accepted,
    output logic [2:0]                     o_command,
    output logic                           o_timed_out,
    output logic                           o_no_position
);
    import fps_pkg::*;

    t_cfg    r_cfg;
    t_item   front_item;
    t_item   queue_item;
    t_result back_result;
    t_result out_result;
    logic    front_push;
    logic    queue_empty;
    logic    back_take;
    logic    out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.takeoff_height <= TAKEOFF_HEIGHT_RST;
            r_cfg.hover_height   <= HOVER_HEIGHT_RST;
            r_cfg.landed_height  <= LANDED_HEIGHT_RST;
            r_cfg.takeoff_limit  <= TAKEOFF_LIMIT_RST;
            r_cfg.hover_limit    <= HOVER_LIMIT_RST;
            r_cfg.landing_limit  <= LANDING_LIMIT_RST;
            r_cfg.max_step       <= MAX_STEP_RST;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_index))
                REG_TAKEOFF_HEIGHT: r_cfg.takeoff_height <= i_cfg_data[HEIGHT_W-1:0];
                REG_HOVER_HEIGHT:   r_cfg.hover_height   <= i_cfg_data[HEIGHT_W-1:0];
                REG_LANDED_HEIGHT:  r_cfg.landed_height  <= i_cfg_data[HEIGHT_W-1:0];
                REG_TAKEOFF_LIMIT:  r_cfg.takeoff_limit  <= i_cfg_data[TIME_W-1:0];
                REG_HOVER_LIMIT:    r_cfg.hover_limit    <= i_cfg_data[TIME_W-1:0];
                REG_LANDING_LIMIT:  r_cfg.landing_limit  <= i_cfg_data[TIME_W-1:0];
                REG_MAX_STEP:       r_cfg.max_step       <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    fps_front u_front (
        .i_push        (push),
        .i_action      (i_action),
        .i_altitude_mm (i_altitude_mm),
        .i_elapsed_ms  (i_elapsed_ms),
        .i_command_ok  (i_command_ok),
        .i_max_step    (r_cfg.max_step),
        .i_queue_full  (full),
        .o_queue_push  (front_push),
        .o_item        (front_item)
    );

    fps_queue #(
        .DEPTH  (IN_DEPTH),
        .t_data (t_item)
    ) u_in_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_item),
        .o_full  (full),
        .i_pop   (back_take),
        .o_data  (queue_item),
        .o_empty (queue_empty)
    );

    fps_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (!queue_empty),
        .i_item   (queue_item),
        .i_room   (!out_full),
        .o_take   (back_take),
        .o_result (back_result)
    );

    fps_queue #(
        .DEPTH  (OUT_DEPTH),
        .t_data (t_result)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_take),
        .i_data  (back_result),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_result),
        .o_empty (empty)
    );

    assign o_phase       = out_result.phase;
    assign o_accepted    = out_result.accepted;
    assign o_command     = out_result.command;
    assign o_timed_out   = out_result.timed_out;
    assign o_no_position = out_result.no_position;

endmodule

FILE: hdl/fps_queue.sv
// ----------------------------------------------------------------------------
// fps_queue
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
`include "flight_phase_sequencer_assert.svh"

module fps_queue #(
    parameter int  DEPTH = 2,
    parameter type t_data = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_data i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_data o_data,
    output logic  o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_data            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `FPS_ASSERT_ALWAYS(a_empty_after_rst, i_clk, !i_rst_n |=> o_empty)
    `FPS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= FULL_CNT)
    `FPS_ASSERT(a_push_only_grows, i_clk, i_rst_n, (do_push && !do_pop) |=> r_count == $past(r_count) + 1'b1)
    `FPS_ASSERT(a_ptr_gap, i_clk, i_rst_n, (r_count == '0 || r_count == FULL_CNT) |-> r_wr_ptr == r_rd_ptr)

endmodule

FILE: hdl/fps_front.sv
// ----------------------------------------------------------------------------
// fps_front
// decodes the action code and clamps the tick step before queueing
// ----------------------------------------------------------------------------
module fps_front (
    input  logic                         i_push,
    input  logic [fps_pkg::ACTION_W-1:0] i_action,
    input  logic [fps_pkg::ALT_W-1:0]    i_altitude_mm,
    input  logic [fps_pkg::STEP_W-1:0]   i_elapsed_ms,
    input  logic                         i_command_ok,
    input  logic [fps_pkg::STEP_W-1:0]   i_max_step,
    input  logic                         i_queue_full,
    output logic                         o_queue_push,
    output fps_pkg::t_item               o_item
);
    import fps_pkg::*;

    t_op op;

    always_comb begin
        case (t_action'(i_action))
            ACT_TICK:     op = OP_TICK;
            ACT_POSITION: op = OP_POSITION;
            ACT_ARM:      op = OP_ARM;
            ACT_DISARM:   op = OP_DISARM;
            ACT_TAKEOFF:  op = OP_TAKEOFF;
            ACT_HOVER:    op = OP_HOVER;
            ACT_TRACK:    op = OP_TRACK;
            ACT_LAND:     op = OP_LAND;
            ACT_SHUTDOWN: op = OP_SHUTDOWN;
            default:      op = OP_NONE;
        endcase
    end

    always_comb begin
        o_item.op       = op;
        o_item.altitude = $signed(i_altitude_mm);
        o_item.step     = (i_elapsed_ms < i_max_step) ? i_elapsed_ms : i_max_step;
        o_item.ok       = i_command_ok;
    end

    assign o_queue_push = i_push && !i_queue_full;

endmodule

FILE: hdl/fps_back.sv
// ----------------------------------------------------------------------------
// fps_back
// flight phase state machine, phase timer and altitude checks
// ----------------------------------------------------------------------------
`include "flight_phase_sequencer_assert.svh"

module fps_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fps_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    input  fps_pkg::t_item   i_item,
    input  logic             i_room,
    output logic             o_take,
    output fps_pkg::t_result o_result
);
    import fps_pkg::*;

    t_phase                   r_phase, n_phase;
    logic signed [ALT_W-1:0]  r_alt, n_alt;
    logic                     r_seen, n_seen;
    logic [TIME_W-1:0]        r_timer, n_timer;

    logic                     go;
    logic [TIME_W:0]          sum;
    logic [TIME_W-1:0]        tick_timer;
    logic [TIME_W-1:0]        limit;
    logic signed [ALT_W:0]    alt_ext;
    logic signed [ALT_W:0]    height;
    logic                     timed_phase;
    logic                     reached;
    logic                     over;
    t_phase                   done_phase;
    t_cmd                     retry_cmd;
    logic                     tick_live;
    logic                     req_pass;
    t_phase                   req_phase;
    t_cmd                     req_cmd;

    assign go         = i_valid && i_room;
    assign o_take     = go;
    assign sum        = {1'b0, r_timer} + (TIME_W + 1)'(i_item.step);
    assign tick_timer = sum[TIME_W] ? TIMER_MAX : sum[TIME_W-1:0];
    assign alt_ext    = {r_alt[ALT_W-1], r_alt};
    assign tick_live  = (i_item.op == OP_TICK) && r_seen;

    always_comb begin
        case (r_phase)
            PH_TAKING_OFF: begin
                timed_phase = 1'b1;
                limit       = i_cfg.takeoff_limit;
                height      = $signed({2'b00, i_cfg.takeoff_height});
                reached     = alt_ext >= height;
                done_phase  = PH_TAKEN_OFF;
                retry_cmd   = CMD_TAKEOFF;
            end
            PH_HOVERING: begin
                timed_phase = 1'b1;
                limit       = i_cfg.hover_limit;
                height      = $signed({2'b00, i_cfg.hover_height});
                reached     = alt_ext >= height;
                done_phase  = PH_HOVERED;
                retry_cmd   = CMD_HOVER;
            end
            PH_LANDING: begin
                timed_phase = 1'b1;
                limit       = i_cfg.landing_limit;
                height      = $signed({2'b00, i_cfg.landed_height});
                reached     = alt_ext <= height;
                done_phase  = PH_LANDED;
                retry_cmd   = CMD_LAND;
            end
            default: begin
                timed_phase = 1'b0;
                limit       = '0;
                height      = '0;
                reached     = 1'b0;
                done_phase  = r_phase;
                retry_cmd   = CMD_NONE;
            end
        endcase
    end

    assign over = timed_phase && (tick_timer > limit);

    // request gates
    always_comb begin
        req_pass  = 1'b0;
        req_phase = r_phase;
        req_cmd   = CMD_NONE;
        case (i_item.op)
            OP_ARM: begin
                req_pass  = (r_phase == PH_DISARMED) && i_item.ok;
                req_phase = PH_ARMED;
                req_cmd   = CMD_ARM;
            end
            OP_DISARM: begin
                req_pass  = (r_phase == PH_ARMED || r_phase == PH_LANDED) && i_item.ok;
                req_phase = PH_DISARMED;
                req_cmd   = CMD_DISARM;
            end
            OP_TAKEOFF: begin
                req_pass  = (r_phase == PH_ARMED) && i_item.ok;
                req_phase = PH_TAKING_OFF;
                req_cmd   = CMD_TAKEOFF;
            end
            OP_HOVER: begin
                req_pass  = (r_phase == PH_TAKEN_OFF || r_phase == PH_TRACKING) && i_item.ok;
                req_phase = PH_HOVERING;
                req_cmd   = CMD_HOVER;
            end
            OP_TRACK: begin
                req_pass  = (r_phase == PH_HOVERED) && i_item.ok;
                req_phase = PH_TRACKING;
                req_cmd   = CMD_NONE;
            end
            OP_LAND: begin
                req_pass  = (r_phase == PH_HOVERING || r_phase == PH_HOVERED
                             || r_phase == PH_TRACKING) && i_item.ok;
                req_phase = PH_LANDING;
                req_cmd   = CMD_LAND;
            end
            OP_SHUTDOWN: begin
                req_pass  = 1'b1;
                req_phase = PH_IDLE;
                req_cmd   = CMD_NONE;
            end
            default: begin
                req_pass  = 1'b0;
                req_phase = r_phase;
                req_cmd   = CMD_NONE;
            end
        endcase
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_alt   = r_alt;
        n_seen  = r_seen;
        n_timer = r_timer;
        if (go) begin
            if (tick_live) begin
                n_timer = tick_timer;
                if (over) begin
                    if (i_item.ok) begin
                        n_timer = '0;
                    end
                end else if (timed_phase && reached) begin
                    n_phase = done_phase;
                    n_timer = '0;
                end
            end else if (i_item.op == OP_POSITION) begin
                n_alt  = i_item.altitude;
                n_seen = 1'b1;
            end else if (req_pass) begin
                n_phase = req_phase;
                n_timer = '0;
            end
        end
    end

    // result
    always_comb begin
        o_result.phase       = n_phase;
        o_result.accepted    = req_pass;
        o_result.timed_out   = tick_live && over;
        o_result.no_position = (i_item.op == OP_TICK) && !r_seen;
        if (req_pass) begin
            o_result.command = req_cmd;
        end else if (tick_live && over && i_item.ok) begin
            o_result.command = retry_cmd;
        end else begin
            o_result.command = CMD_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DISARMED;
            r_alt   <= '0;
            r_seen  <= 1'b0;
            r_timer <= '0;
        end else begin
            r_phase <= n_phase;
            r_alt   <= n_alt;
            r_seen  <= n_seen;
            r_timer <= n_timer;
        end
    end

    `FPS_ASSERT(a_idle_holds, i_clk, i_rst_n, r_phase == PH_IDLE |=> r_phase == PH_IDLE)
    `FPS_ASSERT(a_timer_restart, i_clk, i_rst_n, ($past(i_rst_n) && r_phase != $past(r_phase)) |-> r_timer == '0)
    `FPS_ASSERT(a_cmd_cause, i_clk, i_rst_n, (go && o_result.command != CMD_NONE) |-> (o_result.accepted || o_result.timed_out))
    `FPS_ASSERT(a_seen_sticks, i_clk, i_rst_n, r_seen |=> r_seen)

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the flight phase sequencer: a generator builds
// flights that follow the phase table, with random altitudes, tick times
// and command failures mixed in, and a queue-fed driver pushes them with
// random gaps. A scoreboard predicts every result from its own copy of the
// phase state and checks each popped result field by field. The limits,
// heights and tick clamp are rewritten between runs while the block is
// idle, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fps_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_GAP     = 10;
    localparam int REPORT_MAX  = 10;
    localparam int ALT_MIN     = -8388608;
    localparam int ALT_MAX     = 8388607;
    localparam int ELAPSED_MAX = 65535;
    localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 4'd9;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 4'd15;
    localparam logic [HEIGHT_W-1:0] HEIGHT_TOP = '1;
    localparam logic [STEP_W-1:0]   STEP_TOP   = '1;

    typedef struct packed {
        logic [ACTION_W-1:0]     action;
        logic signed [ALT_W-1:0] altitude;
        logic [STEP_W-1:0]       elapsed;
        logic                    ok;
    } t_flight_event;

    typedef struct packed {
        t_phase                  phase;
        logic signed [ALT_W-1:0] altitude;
        logic                    seen;
        logic [TIME_W-1:0]       timer;
    } t_flight_state;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    push = 1'b0;
    logic                    full;
    logic [ACTION_W-1:0]     i_action = '0;
    logic signed [ALT_W-1:0] i_altitude_mm = '0;
    logic [STEP_W-1:0]       i_elapsed_ms = '0;
    logic                    i_command_ok = 1'b0;
    logic                    empty;
    logic                    pop = 1'b0;
    logic [3:0]              o_phase;
    logic                    o_accepted;
    logic [2:0]              o_command;
    logic                    o_timed_out;
    logic                    o_no_position;

    t_flight_event waiting_events[$];
    t_result       expected_results[$];
    t_flight_state plan_state;
    t_flight_state sb_state;
    t_cfg          plan_cfg;
    t_cfg          sb_cfg;

    int   miss_pct = 50;
    int   mismatches = 0;
    int   cycles = 0;
    int   send_gap = 0;
    int   recv_gap = 0;
    bit   send_burst = 1'b0;
    bit   recv_burst = 1'b0;
    logic event_taken = 1'b0;
    logic result_taken = 1'b0;

    flight_phase_sequencer DUT (.*);

    initial begin : clock_gen
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_cfg default_limits();
        t_cfg c;
        c.takeoff_height = TAKEOFF_HEIGHT_RST;
        c.hover_height   = HOVER_HEIGHT_RST;
        c.landed_height  = LANDED_HEIGHT_RST;
        c.takeoff_limit  = TAKEOFF_LIMIT_RST;
        c.hover_limit    = HOVER_LIMIT_RST;
        c.landing_limit  = LANDING_LIMIT_RST;
        c.max_step       = MAX_STEP_RST;
        return c;
    endfunction

    function automatic t_flight_state power_on_state();
        t_flight_state st;
        st.phase    = PH_DISARMED;
        st.altitude = '0;
        st.seen     = 1'b0;
        st.timer    = '0;
        return st;
    endfunction

    // phase sequencing for one item
    task automatic sequence_phase(inout t_flight_state st, input t_cfg c,
                                  input t_flight_event ev, output t_result r);
        logic [STEP_W-1:0] dt;
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] limit;
        logic              reached;
        t_cmd              retry;
        t_phase            next;
        r.accepted    = 1'b0;
        r.command     = CMD_NONE;
        r.timed_out   = 1'b0;
        r.no_position = 1'b0;
        case (ev.action)
            ACT_TICK: begin
                if (!st.seen) begin
                    r.no_position = 1'b1;
                end else begin
                    dt = (ev.elapsed < c.max_step) ? ev.elapsed : c.max_step;
                    sum = {1'b0, st.timer} + (TIME_W + 1)'(dt);
                    st.timer = sum[TIME_W] ? TIMER_MAX : sum[TIME_W-1:0];
                    case (st.phase)
                        PH_TAKING_OFF: begin
                            limit = c.takeoff_limit;
                            retry = CMD_TAKEOFF;
                            next = PH_TAKEN_OFF;
                            reached = st.altitude >= $signed({1'b0, c.takeoff_height});
                        end
                        PH_HOVERING: begin
                            limit = c.hover_limit;
                            retry = CMD_HOVER;
                            next = PH_HOVERED;
                            reached = st.altitude >= $signed({1'b0, c.hover_height});
                        end
                        PH_LANDING: begin
                            limit = c.landing_limit;
                            retry = CMD_LAND;
                            next = PH_LANDED;
                            reached = st.altitude <= $signed({1'b0, c.landed_height});
                        end
                        default: begin
                            limit = TIMER_MAX;
                            retry = CMD_NONE;
                            next = st.phase;
                            reached = 1'b0;
                        end
                    endcase
                    if (st.timer > limit) begin
                        r.timed_out = 1'b1;
                        if (ev.ok) begin
                            r.command = retry;
                            st.timer = '0;
                        end
                    end else if (reached) begin
                        st.phase = next;
                        st.timer = '0;
                    end
                end
            end
            ACT_POSITION: begin
                st.altitude = ev.altitude;
                st.seen = 1'b1;
            end
            ACT_ARM: begin
                if (st.phase == PH_DISARMED && ev.ok) begin
                    r.accepted = 1'b1;
                    r.command = CMD_ARM;
                    st.phase = PH_ARMED;
                    st.timer = '0;
                end
            end
            ACT_DISARM: begin
                if ((st.phase == PH_ARMED || st.phase == PH_LANDED) && ev.ok) begin
                    r.accepted = 1'b1;
                    r.command = CMD_DISARM;
                    st.phase = PH_DISARMED;
                    st.timer = '0;
                end
            end
            ACT_TAKEOFF: begin
                if (st.phase == PH_ARMED && ev.ok) begin
                    r.accepted = 1'b1;
                    r.command = CMD_TAKEOFF;
                    st.phase = PH_TAKING_OFF;
                    st.timer = '0;
                end
            end
            ACT_HOVER: begin
                if ((st.phase == PH_TAKEN_OFF || st.phase == PH_TRACKING) && ev.ok) begin
                    r.accepted = 1'b1;
                    r.command = CMD_HOVER;
                    st.phase = PH_HOVERING;
                    st.timer = '0;
                end
            end
            ACT_TRACK: begin
                if (st.phase == PH_HOVERED && ev.ok) begin
                    r.accepted = 1'b1;
                    st.phase = PH_TRACKING;
                    st.timer = '0;
                end
            end
            ACT_LAND: begin
                if ((st.phase == PH_HOVERING || st.phase == PH_HOVERED ||
                     st.phase == PH_TRACKING) && ev.ok) begin
                    r.accepted = 1'b1;
                    r.command = CMD_LAND;
                    st.phase = PH_LANDING;
                    st.timer = '0;
                end
            end
            ACT_SHUTDOWN: begin
                r.accepted = 1'b1;
                st.phase = PH_IDLE;
                st.timer = '0;
            end
            default: ;
        endcase
        r.phase = st.phase;
    endtask

    task automatic apply_reg(inout t_cfg c, input t_reg idx,
                             input logic [CFG_DATA_W-1:0] v);
        case (idx)
            REG_TAKEOFF_HEIGHT: c.takeoff_height = v[HEIGHT_W-1:0];
            REG_HOVER_HEIGHT:   c.hover_height   = v[HEIGHT_W-1:0];
            REG_LANDED_HEIGHT:  c.landed_height  = v[HEIGHT_W-1:0];
            REG_TAKEOFF_LIMIT:  c.takeoff_limit  = v[TIME_W-1:0];
            REG_HOVER_LIMIT:    c.hover_limit    = v[TIME_W-1:0];
            REG_LANDING_LIMIT:  c.landing_limit  = v[TIME_W-1:0];
            REG_MAX_STEP:       c.max_step       = v[STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_reg(t_reg idx, logic [CFG_DATA_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        apply_reg(plan_cfg, idx, v);
        apply_reg(sb_cfg, idx, v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(t_cfg c);
        write_reg(REG_TAKEOFF_HEIGHT, CFG_DATA_W'(c.takeoff_height));
        write_reg(REG_HOVER_HEIGHT,   CFG_DATA_W'(c.hover_height));
        write_reg(REG_LANDED_HEIGHT,  CFG_DATA_W'(c.landed_height));
        write_reg(REG_TAKEOFF_LIMIT,  CFG_DATA_W'(c.takeoff_limit));
        write_reg(REG_HOVER_LIMIT,    CFG_DATA_W'(c.hover_limit));
        write_reg(REG_LANDING_LIMIT,  CFG_DATA_W'(c.landing_limit));
        write_reg(REG_MAX_STEP,       CFG_DATA_W'(c.max_step));
    endtask

    function automatic logic signed [ALT_W-1:0] to_altitude(int v);
        if (v < ALT_MIN) v = ALT_MIN;
        if (v > ALT_MAX) v = ALT_MAX;
        return v[ALT_W-1:0];
    endfunction

    function automatic logic cmd_ok();
        return $urandom_range(0, 9) != 0;
    endfunction

    function automatic int tick_ms();
        int top;
        top = 2 * int'(plan_cfg.max_step);
        if (top > ELAPSED_MAX) top = ELAPSED_MAX;
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, ELAPSED_MAX);
        return $urandom_range(0, top);
    endfunction

    task automatic add_event(logic [ACTION_W-1:0] a, int alt, int el, logic ok);
        t_flight_event ev;
        t_result       r;
        ev.action   = a;
        ev.altitude = to_altitude(alt);
        ev.elapsed  = el[STEP_W-1:0];
        ev.ok       = ok;
        sequence_phase(plan_state, plan_cfg, ev, r);
        waiting_events.push_back(ev);
    endtask

    // climb towards or sink below a threshold, missing it now and then
    task automatic approach(int h, bit up);
        int off;
        bit hit;
        if ($urandom_range(0, 1) == 0) begin
            add_event(ACT_TICK, 0, tick_ms(), cmd_ok());
        end else begin
            off = $urandom_range(0, 300);
            hit = $urandom_range(0, 99) >= miss_pct;
            if (up) add_event(ACT_POSITION, hit ? h + off : h - 1 - off, 0, cmd_ok());
            else add_event(ACT_POSITION, hit ? h - off : h + 1 + off, 0, cmd_ok());
        end
    endtask

    task automatic noise_event(output bit counted);
        logic [ACTION_W-1:0] a;
        if ($urandom_range(0, 9) == 0)
            a = ACTION_W'($urandom_range(int'(ACT_SPARE_LO), int'(ACT_SPARE_HI)));
        else
            a = ACTION_W'($urandom_range(int'(ACT_TICK), int'(ACT_LAND)));
        counted = a <= ACT_LAND;
        add_event(a, int'($urandom_range(0, 16777215)) + ALT_MIN,
                  $urandom_range(0, ELAPSED_MAX), 1'($urandom_range(0, 1)));
    endtask

    task automatic fly(int n);
        int made;
        bit counted;
        made = 0;
        while (made < n) begin
            counted = 1'b1;
            if ($urandom_range(0, 99) < 22) begin
                noise_event(counted);
            end else begin
                case (plan_state.phase)
                    PH_DISARMED: add_event(ACT_ARM, 0, 0, cmd_ok());
                    PH_ARMED: add_event($urandom_range(0, 6) == 0 ? ACT_DISARM : ACT_TAKEOFF,
                                        0, 0, cmd_ok());
                    PH_TAKING_OFF: approach(int'(plan_cfg.takeoff_height), 1'b1);
                    PH_TAKEN_OFF: add_event(ACT_HOVER, 0, 0, cmd_ok());
                    PH_HOVERING: begin
                        if ($urandom_range(0, 4) == 0) add_event(ACT_LAND, 0, 0, cmd_ok());
                        else approach(int'(plan_cfg.hover_height), 1'b1);
                    end
                    PH_HOVERED: add_event($urandom_range(0, 1) ? ACT_TRACK : ACT_LAND,
                                          0, 0, cmd_ok());
                    PH_TRACKING: add_event($urandom_range(0, 1) ? ACT_HOVER : ACT_LAND,
                                           0, 0, cmd_ok());
                    PH_LANDING: approach(int'(plan_cfg.landed_height), 1'b0);
                    PH_LANDED: add_event(ACT_DISARM, 0, 0, cmd_ok());
                    default: noise_event(counted);
                endcase
            end
            if (counted) made++;
        end
    endtask

    // sender holds off until every result is back
    task automatic settle();
        while (waiting_events.size() != 0 || push || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic note_mismatch(string msg);
        if (mismatches < REPORT_MAX) $display("mismatch: %s", msg);
        mismatches++;
    endtask

    task automatic check_field(string what, int want, int got);
        if (want != got)
            note_mismatch($sformatf("%s expected %0d, got %0d", what, want, got));
    endtask

    initial begin : stimulus
        t_cfg c;
        plan_cfg = default_limits();
        sb_cfg = plan_cfg;
        plan_state = power_on_state();
        sb_state = plan_state;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // tick with no position, gate and command refusals, spare codes
        add_event(ACT_TICK, 0, ELAPSED_MAX, 1'b1);
        add_event(ACT_ARM, 0, 0, 1'b0);
        add_event(ACT_TAKEOFF, 0, 0, 1'b1);
        add_event(ACT_SPARE_HI, -1, ELAPSED_MAX, 1'b1);
        add_event(ACT_POSITION, ALT_MIN, 0, 1'b1);
        add_event(ACT_TICK, 0, 0, 1'b1);
        add_event(ACT_ARM, 0, 0, 1'b1);
        add_event(ACT_DISARM, 0, 0, 1'b1);
        add_event(ACT_ARM, 0, 0, 1'b1);
        add_event(ACT_TAKEOFF, 0, 0, 1'b1);
        add_event(ACT_TICK, 0, ELAPSED_MAX, 1'b1);
        add_event(ACT_POSITION, int'(TAKEOFF_HEIGHT_RST), 0, 1'b1);
        add_event(ACT_TICK, 0, 100, 1'b1);
        add_event(ACT_TRACK, 0, 0, 1'b1);
        add_event(ACT_HOVER, 0, 0, 1'b1);
        add_event(ACT_POSITION, ALT_MAX, 0, 1'b1);
        add_event(ACT_TICK, 0, 0, 1'b1);
        add_event(ACT_TRACK, 0, 0, 1'b1);
        add_event(ACT_HOVER, 0, 0, 1'b1);
        add_event(ACT_LAND, 0, 0, 1'b0);
        add_event(ACT_LAND, 0, 0, 1'b1);
        add_event(ACT_POSITION, int'(LANDED_HEIGHT_RST), 0, 1'b1);
        add_event(ACT_TICK, 0, int'(MAX_STEP_RST), 1'b1);
        add_event(ACT_DISARM, 0, 0, 1'b1);
        add_event(ACT_SPARE_LO, 0, 0, 1'b0);
        fly(300);
        settle();

        // short limits, timeouts and retries
        c.takeoff_height = HEIGHT_W'($urandom_range(0, 5000));
        c.hover_height   = HEIGHT_W'($urandom_range(0, 5000));
        c.landed_height  = HEIGHT_W'($urandom_range(0, 5000));
        c.takeoff_limit  = TIME_W'($urandom_range(0, 3000));
        c.hover_limit    = TIME_W'($urandom_range(0, 3000));
        c.landing_limit  = TIME_W'($urandom_range(0, 3000));
        c.max_step       = STEP_W'($urandom_range(1, 400));
        write_all(c);
        miss_pct = 60;
        fly(300);
        settle();

        c.takeoff_height = '0;
        c.hover_height   = '0;
        c.landed_height  = '0;
        c.takeoff_limit  = '0;
        c.hover_limit    = '0;
        c.landing_limit  = '0;
        c.max_step       = 16'd1;
        write_all(c);
        miss_pct = 50;
        fly(250);
        settle();

        // top values, long phases drive the timer into saturation
        c.takeoff_height = HEIGHT_TOP;
        c.hover_height   = HEIGHT_TOP;
        c.landed_height  = HEIGHT_TOP;
        c.takeoff_limit  = TIMER_MAX;
        c.hover_limit    = TIMER_MAX;
        c.landing_limit  = TIMER_MAX;
        c.max_step       = STEP_TOP;
        write_all(c);
        miss_pct = 97;
        fly(250);
        settle();

        c.takeoff_height = HEIGHT_W'($urandom_range(0, int'(HEIGHT_TOP)));
        c.hover_height   = HEIGHT_W'($urandom_range(0, int'(HEIGHT_TOP)));
        c.landed_height  = HEIGHT_W'($urandom_range(0, int'(HEIGHT_TOP)));
        c.takeoff_limit  = TIME_W'($urandom_range(0, 20000));
        c.hover_limit    = TIME_W'($urandom_range(0, 20000));
        c.landing_limit  = TIME_W'($urandom_range(0, 20000));
        c.max_step       = STEP_W'($urandom_range(1, int'(STEP_TOP)));
        write_all(c);
        miss_pct = 50;
        fly(250);
        settle();

        write_all(default_limits());
        fly(250);

        // shutdown is unconditional and idle holds until reset
        add_event(ACT_SHUTDOWN, 0, 0, 1'b0);
        fly(15);
        settle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS flight_phase_sequencer");
        end else begin
            $display("FAIL flight_phase_sequencer");
        end
        $finish;
    end

    always @(negedge i_clk) begin : driver
        t_flight_event ev;
        logic drive;
        drive = push;
        if (i_rst_n && (!push || event_taken)) begin
            drive = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (waiting_events.size() != 0) begin
                ev = waiting_events.pop_front();
                i_action <= ev.action;
                i_altitude_mm <= ev.altitude;
                i_elapsed_ms <= ev.elapsed;
                i_command_ok <= ev.ok;
                drive = 1'b1;
                if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
        end
        push <= drive;
    end

    always @(negedge i_clk) begin : popper
        if (i_rst_n) begin
            if (result_taken) begin
                if ($urandom_range(0, 49) == 0) recv_burst = !recv_burst;
                recv_gap = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : scoreboard
        t_flight_event ev;
        t_result       want;
        t_result       pred;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL flight_phase_sequencer");
            $finish;
        end else if (!i_rst_n) begin
            event_taken <= 1'b0;
            result_taken <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    note_mismatch($sformatf("result with no item waiting, phase %0d", o_phase));
                end else begin
                    want = expected_results.pop_front();
                    check_field("phase", want.phase, o_phase);
                    check_field("accepted", want.accepted, o_accepted);
                    check_field("command", want.command, o_command);
                    check_field("timed_out", want.timed_out, o_timed_out);
                    check_field("no_position", want.no_position, o_no_position);
                end
            end
            if (push && !full) begin
                ev.action   = i_action;
                ev.altitude = i_altitude_mm;
                ev.elapsed  = i_elapsed_ms;
                ev.ok       = i_command_ok;
                sequence_phase(sb_state, sb_cfg, ev, pred);
                expected_results.push_back(pred);
            end
            result_taken <= pop && !empty;
            event_taken <= push && !full;
        end
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/fps_pkg.sv
hdl/fps_queue.sv
hdl/fps_front.sv
hdl/fps_back.sv
hdl/flight_phase_sequencer.sv
tb/tb_top.sv
